[sv/corfp_pkg.sv]
// ----------------------------------------------------------------------------
// corfp_pkg
// Shared types, constants and helpers for the center-out ring fade pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package corfp_pkg;

  localparam int unsigned MaxLeds   = 1024;
  localparam int unsigned LenW      = 11;
  localparam int unsigned IdxW      = 10;
  localparam int unsigned Q16W      = 17;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 17;

  localparam logic [Q16W-1:0] Q16One = 17'h10000;

  localparam logic [CfgIdxW-1:0] RegStartCold  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStartWarm  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTargetCold = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTargetWarm = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStripLen   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCenterOut  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegTurningOn  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegOverlap    = 3'd7;

  typedef struct packed {
    logic [IdxW-1:0] led_index;
    logic [Q16W-1:0] progress;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] warm_byte;
    logic [7:0] cold_byte;
  } pixel_out_t;

  // Anything above full scale reads as full scale.
  function automatic logic [Q16W-1:0] sat_q16(input logic [Q16W-1:0] v);
    logic [Q16W-1:0] r;
    r = v[Q16W-1] ? Q16One : v;
    return r;
  endfunction

endpackage

[sv/center_out_ring_fade_pixel.sv]
// ----------------------------------------------------------------------------
// center_out_ring_fade_pixel
// Per-LED warm/cold white drive bytes for a uniform or center-out ring fade.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one transaction per
//   LED: its index and the smoothed global progress. Output channel
//   (out_valid_o/out_ready_i/out_data_o) returns the warm and cold bytes for
//   that LED, in order, one result per input transaction.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i);
//   it must be written by the user only while no transaction is in flight;
//   the block itself does not enforce this. Throughput is one transaction per
//   cycle while the receiver does not stall. The stages are the ring/phase
//   stage, the ring multiply, the 17x27 progress multiply, the clamp and three
//   blend/round stages (multiply, level sum, byte rounding).
//   When the receiver stalls, the pipeline fills and bubbles collapse;
//   in_ready_o drops only once every stage holds a transaction.
//   Reset empties the pipeline and loads the register defaults: all zero,
//   strip length one.

module center_out_ring_fade_pixel (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [corfp_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [corfp_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  corfp_pkg::pixel_in_t                 in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output corfp_pkg::pixel_out_t                out_data_o
);

  localparam int unsigned NumStages = 7;

  // Configuration registers
  logic [16:0] start_cold_q, start_warm_q, target_cold_q, target_warm_q;
  logic [16:0] overlap_q;
  logic [10:0] strip_len_q;
  logic        center_out_q, turning_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_cold_q  <= '0;
      start_warm_q  <= '0;
      target_cold_q <= '0;
      target_warm_q <= '0;
      strip_len_q   <= 11'd1;
      center_out_q  <= 1'b0;
      turning_on_q  <= 1'b0;
      overlap_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        corfp_pkg::RegStartCold:  start_cold_q  <= cfg_wdata_i[16:0];
        corfp_pkg::RegStartWarm:  start_warm_q  <= cfg_wdata_i[16:0];
        corfp_pkg::RegTargetCold: target_cold_q <= cfg_wdata_i[16:0];
        corfp_pkg::RegTargetWarm: target_warm_q <= cfg_wdata_i[16:0];
        corfp_pkg::RegStripLen:   strip_len_q   <= cfg_wdata_i[10:0];
        corfp_pkg::RegCenterOut:  center_out_q  <= cfg_wdata_i[0];
        corfp_pkg::RegTurningOn:  turning_on_q  <= cfg_wdata_i[0];
        corfp_pkg::RegOverlap:    overlap_q     <= cfg_wdata_i[16:0];
        default: ;
      endcase
    end
  end

  // Saturated configuration values
  logic [16:0] sc_sat, sw_sat, tc_sat, tw_sat, q_w;
  assign sc_sat = corfp_pkg::sat_q16(start_cold_q);
  assign sw_sat = corfp_pkg::sat_q16(start_warm_q);
  assign tc_sat = corfp_pkg::sat_q16(target_cold_q);
  assign tw_sat = corfp_pkg::sat_q16(target_warm_q);
  assign q_w    = corfp_pkg::Q16One - corfp_pkg::sat_q16(overlap_q);

  // Pipeline flow control
  logic [NumStages-1:0] v_q, en;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o = en[0];

  // Stage 0: ring and phase of the LED
  logic [10:0] len_c;
  logic [9:0]  nm1, idx_c, mirror, edge_c;
  logic [8:0]  half, ring_c, phase_d;
  logic [16:0] p_d;

  always_comb begin
    len_c = strip_len_q;
    if (len_c == 11'd0) begin
      len_c = 11'd1;
    end else if (len_c > 11'(corfp_pkg::MaxLeds)) begin
      len_c = 11'(corfp_pkg::MaxLeds);
    end
    nm1    = 10'(len_c - 11'd1);
    idx_c  = (in_data_i.led_index > nm1) ? nm1 : in_data_i.led_index;
    mirror = nm1 - idx_c;
    edge_c = (idx_c < mirror) ? idx_c : mirror;
    half   = nm1[9:1];
    ring_c = half - edge_c[8:0];
    // rings-1-ring equals the edge distance
    phase_d = turning_on_q ? ring_c : edge_c[8:0];
    p_d     = corfp_pkg::sat_q16(in_data_i.progress);
  end

  logic [16:0] st1_p_q;
  logic [8:0]  st1_phase_q, st1_half_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      st1_p_q     <= p_d;
      st1_phase_q <= phase_d;
      st1_half_q  <= half;
    end
  end

  // Stage 1: phase*q and (rings-1)*q
  logic [25:0] phq_d, hq_d;
  assign phq_d = 26'(st1_phase_q) * 26'(q_w);
  assign hq_d  = 26'(st1_half_q) * 26'(q_w);

  logic [16:0] st2_p_q;
  logic [25:0] st2_phq_q, st2_hq_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      st2_p_q   <= st1_p_q;
      st2_phq_q <= phq_d;
      st2_hq_q  <= hq_d;
    end
  end

  // Stage 2: p*(1 + (rings-1)*q)
  logic [26:0] scale_c;
  logic [43:0] pa_d;
  assign scale_c = {1'b0, st2_hq_q} + 27'd65536;
  assign pa_d    = 44'(st2_p_q) * 44'(scale_c);

  logic [16:0] st3_p_q;
  logic [43:0] st3_pa_q;
  logic [25:0] st3_phq_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      st3_p_q   <= st2_p_q;
      st3_pa_q  <= pa_d;
      st3_phq_q <= st2_phq_q;
    end
  end

  // Stage 3: center-out subtracts phase offset, clamps, rounds to Q1.16; else p
  logic signed [44:0] t_c;
  logic [32:0]        tc_c;
  logic [33:0]        tr_c;
  logic [16:0]        lp_d;

  always_comb begin
    t_c = $signed({1'b0, st3_pa_q}) - $signed({3'b0, st3_phq_q, 16'b0});
    if (t_c < 45'sd0) begin
      tc_c = '0;
    end else if (t_c > 45'sd4294967296) begin
      tc_c = 33'h1_0000_0000;
    end else begin
      tc_c = t_c[32:0];
    end
    tr_c = {1'b0, tc_c} + 34'd32768;
    lp_d = center_out_q ? tr_c[32:16] : st3_p_q;
  end

  logic [16:0] st4_lp_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      st4_lp_q <= lp_d;
    end
  end

  // Stage 4: (e - s) * lp
  logic signed [17:0] dw_c, dc_c, lp_s;
  logic signed [35:0] prod_w_d, prod_c_d;

  always_comb begin
    dw_c     = $signed({1'b0, tw_sat}) - $signed({1'b0, sw_sat});
    dc_c     = $signed({1'b0, tc_sat}) - $signed({1'b0, sc_sat});
    lp_s     = $signed({1'b0, st4_lp_q});
    prod_w_d = 36'(dw_c) * 36'(lp_s);
    prod_c_d = 36'(dc_c) * 36'(lp_s);
  end

  logic signed [35:0] st5_prod_w_q, st5_prod_c_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      st5_prod_w_q <= prod_w_d;
      st5_prod_c_q <= prod_c_d;
    end
  end

  // Stage 5: level in Q1.32
  logic signed [35:0] lvl_w_c, lvl_c_c;
  assign lvl_w_c = $signed({3'b0, sw_sat, 16'b0}) + st5_prod_w_q;
  assign lvl_c_c = $signed({3'b0, sc_sat, 16'b0}) + st5_prod_c_q;

  logic [32:0] st6_lvl_w_q, st6_lvl_c_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      st6_lvl_w_q <= lvl_w_c[32:0];
      st6_lvl_c_q <= lvl_c_c[32:0];
    end
  end

  // Stage 6: byte = round(level * 255), half up
  logic [40:0] bw_c, bc_c;
  assign bw_c = ({st6_lvl_w_q, 8'b0} - {8'b0, st6_lvl_w_q}) + 41'd2147483648;
  assign bc_c = ({st6_lvl_c_q, 8'b0} - {8'b0, st6_lvl_c_q}) + 41'd2147483648;

  corfp_pkg::pixel_out_t st7_out_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      st7_out_q.warm_byte <= bw_c[39:32];
      st7_out_q.cold_byte <= bc_c[39:32];
    end
  end

  assign out_valid_o = v_q[NumStages-1];
  assign out_data_o  = st7_out_q;

  // Assertions
  a_empty_out_opens_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NumStages-1] |-> in_ready_o)
    else $error("empty output stage blocks input");

  a_taken_out_opens_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while receiver takes result");

  a_lp_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (st4_lp_q <= corfp_pkg::Q16One))
    else $error("local progress above full scale");

  a_level_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] |-> ((st6_lvl_w_q <= 33'h1_0000_0000) && (st6_lvl_c_q <= 33'h1_0000_0000)))
    else $error("blend level out of range");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for center_out_ring_fade_pixel. A directed table covers
// reset defaults, level and progress extremes, saturation, both fade modes and
// both directions, then randomized configuration phases push random pixels
// through with random idle bursts on both channels and one long output hold-off.
// Every output is checked against its table value or an in-bench fade model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int NumPhases     = 13;
  localparam int ItemsPerPhase = 50;
  localparam int SqueezePhase  = 2;
  localparam int HoldOffCycles = 64;
  localparam int DrainCycles   = 20;
  localparam int CycleLimit    = 200000;

  localparam longint FullQ32 = 64'sd4294967296;
  localparam longint HalfQ32 = 64'sd2147483648;

  typedef enum logic {RowWrite, RowPixel} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [corfp_pkg::CfgIdxW-1:0]  reg_idx;
    logic [corfp_pkg::CfgDataW-1:0] reg_val;
    corfp_pkg::pixel_in_t           pkt;
    logic                           known;
    corfp_pkg::pixel_out_t          want;
  } plan_row_t;

  typedef struct packed {
    corfp_pkg::pixel_in_t  pkt;
    corfp_pkg::pixel_out_t bytes;
  } pixel_expect_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [corfp_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [corfp_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  corfp_pkg::pixel_in_t           in_data_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  corfp_pkg::pixel_out_t          out_data_o;

  logic hold_off_req = 1'b0;
  logic tail_quiet   = 1'b0;

  // shadow copy of the register file
  logic [corfp_pkg::Q16W-1:0] start_cold, start_warm, end_cold, end_warm, overlap;
  logic [corfp_pkg::LenW-1:0] strip_len;
  logic                       ring_mode, powering_on;

  plan_row_t     plan_q[$];
  pixel_expect_t pending_pixels[$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;

  center_out_ring_fade_pixel dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint clip_q16(input logic [corfp_pkg::Q16W-1:0] v);
    return (v > corfp_pkg::Q16One) ? 64'sd65536 : longint'(v);
  endfunction

  function automatic logic [7:0] level_byte(input longint s, input longint e,
                                            input longint lp);
    longint lvl;
    lvl = s * 65536 + (e - s) * lp;
    if (lvl < 0) lvl = 0;
    if (lvl > FullQ32) lvl = FullQ32;
    lvl = (lvl * 255 + HalfQ32) >>> 32;
    if (lvl > 255) lvl = 255;
    return lvl[7:0];
  endfunction

  function automatic corfp_pkg::pixel_out_t fade_bytes(input corfp_pkg::pixel_in_t pkt);
    longint p, lp, n, i, rings, near_edge, ring, phase, q, t;
    corfp_pkg::pixel_out_t r;
    p = clip_q16(pkt.progress);
    lp = p;
    if (ring_mode) begin
      n = (strip_len == '0) ? 64'sd1 : longint'(strip_len);
      if (n > longint'(corfp_pkg::MaxLeds)) n = longint'(corfp_pkg::MaxLeds);
      i = longint'(pkt.led_index);
      if (i > n - 1) i = n - 1;
      rings = (n + 1) / 2;
      near_edge = (i < n - 1 - i) ? i : n - 1 - i;
      ring = (n - 1) / 2 - near_edge;
      phase = powering_on ? ring : rings - 1 - ring;
      q = 65536 - clip_q16(overlap);
      t = p * (65536 + (rings - 1) * q) - phase * q * 65536;
      if (t < 0) t = 0;
      if (t > FullQ32) t = FullQ32;
      lp = (t + 32768) >>> 16;
    end
    r.warm_byte = level_byte(clip_q16(start_warm), clip_q16(end_warm), lp);
    r.cold_byte = level_byte(clip_q16(start_cold), clip_q16(end_cold), lp);
    return r;
  endfunction

  function automatic logic [corfp_pkg::Q16W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return corfp_pkg::Q16One;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic void plan_write(input logic [corfp_pkg::CfgIdxW-1:0] idx,
                                     input logic [corfp_pkg::CfgDataW-1:0] val);
    plan_row_t row;
    row = '0;
    row.kind = RowWrite;
    row.reg_idx = idx;
    row.reg_val = val;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_px(input logic [corfp_pkg::IdxW-1:0] led,
                                  input logic [corfp_pkg::Q16W-1:0] prog,
                                  input logic known, input logic [7:0] warm,
                                  input logic [7:0] cold);
    plan_row_t row;
    row = '0;
    row.kind = RowPixel;
    row.pkt.led_index = led;
    row.pkt.progress = prog;
    row.known = known;
    row.want.warm_byte = warm;
    row.want.cold_byte = cold;
    plan_q.push_back(row);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  task automatic write_reg(input logic [corfp_pkg::CfgIdxW-1:0] idx,
                           input logic [corfp_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    unique case (idx)
      corfp_pkg::RegStartCold:  start_cold = val;
      corfp_pkg::RegStartWarm:  start_warm = val;
      corfp_pkg::RegTargetCold: end_cold = val;
      corfp_pkg::RegTargetWarm: end_warm = val;
      corfp_pkg::RegStripLen:   strip_len = val[corfp_pkg::LenW-1:0];
      corfp_pkg::RegCenterOut:  ring_mode = val[0];
      corfp_pkg::RegTurningOn:  powering_on = val[0];
      corfp_pkg::RegOverlap:    overlap = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input corfp_pkg::pixel_in_t pkt, input logic known,
                            input corfp_pkg::pixel_out_t want);
    pixel_expect_t exp_item;
    in_valid_i <= 1'b1;
    in_data_i  <= pkt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    exp_item.pkt = pkt;
    exp_item.bytes = known ? want : fade_bytes(pkt);
    pending_pixels.push_back(exp_item);
  endtask

  task automatic idle_gap();
    if ($urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // registers only change with nothing in flight
  task automatic settle_pipe();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    corfp_pkg::pixel_in_t       pkt;
    int                         span;
    bit                         steady;
    logic [corfp_pkg::LenW-1:0] len_pick;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    start_cold  = '0;
    start_warm  = '0;
    end_cold    = '0;
    end_warm    = '0;
    strip_len   = 11'd1;
    ring_mode   = 1'b0;
    powering_on = 1'b0;
    overlap     = '0;
    steady      = 1'b0;

    // reset defaults: all levels zero
    plan_px(10'd0, 17'd0, 1'b1, 8'd0, 8'd0);
    plan_px(10'd1023, corfp_pkg::Q16One, 1'b1, 8'd0, 8'd0);
    // uniform fade, warm rises and cold falls
    plan_write(corfp_pkg::RegStartWarm, 17'd0);
    plan_write(corfp_pkg::RegTargetWarm, corfp_pkg::Q16One);
    plan_write(corfp_pkg::RegStartCold, corfp_pkg::Q16One);
    plan_write(corfp_pkg::RegTargetCold, 17'd0);
    plan_px(10'd5, 17'd0, 1'b1, 8'd0, 8'd255);
    plan_px(10'd5, corfp_pkg::Q16One, 1'b1, 8'd255, 8'd0);
    plan_px(10'd5, 17'h1FFFF, 1'b1, 8'd255, 8'd0);
    plan_px(10'd5, 17'h08000, 1'b1, 8'd128, 8'd128);
    // levels above full scale saturate
    plan_write(corfp_pkg::RegStartWarm, 17'h1FFFF);
    plan_write(corfp_pkg::RegTargetWarm, 17'd0);
    plan_write(corfp_pkg::RegStartCold, 17'd0);
    plan_write(corfp_pkg::RegTargetCold, 17'h10001);
    plan_px(10'd0, 17'd0, 1'b1, 8'd255, 8'd0);
    plan_px(10'd0, corfp_pkg::Q16One, 1'b1, 8'd0, 8'd255);
    // center-out, ten LEDs, powering on, no overlap
    plan_write(corfp_pkg::RegStartWarm, 17'd0);
    plan_write(corfp_pkg::RegTargetWarm, corfp_pkg::Q16One);
    plan_write(corfp_pkg::RegStartCold, corfp_pkg::Q16One);
    plan_write(corfp_pkg::RegTargetCold, 17'd0);
    plan_write(corfp_pkg::RegStripLen, 17'd10);
    plan_write(corfp_pkg::RegCenterOut, 17'd1);
    plan_write(corfp_pkg::RegTurningOn, 17'd1);
    plan_write(corfp_pkg::RegOverlap, 17'd0);
    plan_px(10'd4, 17'd0, 1'b1, 8'd0, 8'd255);
    plan_px(10'd4, corfp_pkg::Q16One, 1'b1, 8'd255, 8'd0);
    plan_px(10'd0, 17'd65535, 1'b0, 8'd0, 8'd0);
    plan_px(10'd9, 17'd13107, 1'b0, 8'd0, 8'd0);
    plan_px(10'd5, 17'd26214, 1'b0, 8'd0, 8'd0);
    plan_px(10'd1023, 17'd40000, 1'b0, 8'd0, 8'd0);
    // powering off: outer rings lead
    plan_write(corfp_pkg::RegTurningOn, 17'd0);
    plan_px(10'd0, 17'd20000, 1'b0, 8'd0, 8'd0);
    plan_px(10'd4, corfp_pkg::Q16One, 1'b1, 8'd255, 8'd0);
    plan_px(10'd4, 17'd52428, 1'b0, 8'd0, 8'd0);
    plan_px(10'd0, 17'd0, 1'b1, 8'd0, 8'd255);
    // full overlap collapses to uniform
    plan_write(corfp_pkg::RegOverlap, 17'h1FFFF);
    plan_px(10'd7, 17'h08000, 1'b1, 8'd128, 8'd128);
    // zero length reads as one LED
    plan_write(corfp_pkg::RegStripLen, 17'd0);
    plan_write(corfp_pkg::RegOverlap, 17'h08000);
    plan_px(10'd500, corfp_pkg::Q16One, 1'b1, 8'd255, 8'd0);
    // oversize length clamps to the maximum
    plan_write(corfp_pkg::RegStripLen, 17'h007FF);
    plan_px(10'd511, 17'd30000, 1'b0, 8'd0, 8'd0);
    plan_px(10'd512, 17'd30000, 1'b0, 8'd0, 8'd0);
    plan_px(10'd1023, corfp_pkg::Q16One, 1'b1, 8'd255, 8'd0);
    plan_write(corfp_pkg::RegTurningOn, 17'd1);
    plan_px(10'd0, 17'd65000, 1'b0, 8'd0, 8'd0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[k]) begin
      if (plan_q[k].kind == RowWrite) begin
        settle_pipe();
        write_reg(plan_q[k].reg_idx, plan_q[k].reg_val);
      end else begin
        idle_gap();
        send_pixel(plan_q[k].pkt, plan_q[k].known, plan_q[k].want);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle_pipe();
      case ($urandom_range(0, 7))
        0: len_pick = 11'd0;
        1: len_pick = 11'd1;
        2: len_pick = 11'd2;
        3: len_pick = 11'd1024;
        4: len_pick = 11'($urandom_range(1025, 2047));
        5: len_pick = 11'($urandom_range(1, 1024));
        default: len_pick = 11'($urandom_range(3, 40));
      endcase
      write_reg(corfp_pkg::RegStartCold, pick_level());
      write_reg(corfp_pkg::RegStartWarm, pick_level());
      write_reg(corfp_pkg::RegTargetCold, pick_level());
      write_reg(corfp_pkg::RegTargetWarm, pick_level());
      write_reg(corfp_pkg::RegStripLen, {6'($urandom), len_pick});
      write_reg(corfp_pkg::RegCenterOut, {16'($urandom), $urandom_range(0, 3) != 0});
      write_reg(corfp_pkg::RegTurningOn, {16'($urandom), 1'($urandom)});
      write_reg(corfp_pkg::RegOverlap, pick_level());
      span = (strip_len == '0) ? 1 :
             ((strip_len > corfp_pkg::MaxLeds) ? int'(corfp_pkg::MaxLeds) : int'(strip_len));
      steady = (ph == SqueezePhase) || (ph >= NumPhases - 2);
      if (ph == SqueezePhase) hold_off_req <= 1'b1;
      if (ph == NumPhases - 2) tail_quiet <= 1'b1;

      for (int k = 0; k < ItemsPerPhase; k++) begin
        case ($urandom_range(0, 9))
          0: pkt.led_index = '0;
          1: pkt.led_index = 10'(span - 1);
          2: pkt.led_index = 10'($urandom);
          default: pkt.led_index = 10'($urandom_range(0, span - 1));
        endcase
        case ($urandom_range(0, 9))
          0: pkt.progress = '0;
          1: pkt.progress = corfp_pkg::Q16One;
          2: pkt.progress = 17'($urandom_range(65537, 131071));
          default: pkt.progress = 17'($urandom_range(0, 65536));
        endcase
        if (!steady) idle_gap();
        send_pixel(pkt, 1'b0, '0);
      end
    end

    settle_pipe();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin : ready_driver
    int stall;
    bit held;
    out_ready_i = 1'b0;
    held        = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !held) begin
        // long hold-off so the pipe fills and backs up the input
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        held = 1'b1;
        out_ready_i <= 1'b1;
      end else if (tail_quiet || $urandom_range(0, 4) != 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        stall = int'($urandom_range(1, 11));
        repeat (stall - 1) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    pixel_expect_t exp_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction warm %0d cold %0d",
                                  out_data_o.warm_byte, out_data_o.cold_byte));
      end else begin
        exp_item = pending_pixels.pop_front();
        if (out_data_o.warm_byte !== exp_item.bytes.warm_byte)
          report_mismatch($sformatf("warm_byte %0d, want %0d (led %0d progress %0d)",
                                    out_data_o.warm_byte, exp_item.bytes.warm_byte,
                                    exp_item.pkt.led_index, exp_item.pkt.progress));
        if (out_data_o.cold_byte !== exp_item.bytes.cold_byte)
          report_mismatch($sformatf("cold_byte %0d, want %0d (led %0d progress %0d)",
                                    out_data_o.cold_byte, exp_item.bytes.cold_byte,
                                    exp_item.pkt.led_index, exp_item.pkt.progress));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("ERROR: timeout after %0d cycles, %0d transactions outstanding",
               cycle_count, pending_pixels.size());
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

[sim.f]
sv/corfp_pkg.sv
sv/center_out_ring_fade_pixel.sv
tb/tb_top.sv
